// File: rtl/mrrm_pkg.sv
// Package with the word types, codes and CRC helpers of the Modbus RTU register master.
`default_nettype none
package mrrm_pkg;

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_BYTE    = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT = 2'd3;

  localparam logic [7:0]  FN_READ          = 8'h03;
  localparam logic [7:0]  FN_WRITE         = 8'h06;
  localparam logic [7:0]  BYTE_COUNT_ONE   = 8'h02;
  localparam logic [15:0] READ_COUNT_ONE   = 16'h0001;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam int  PADDR_W = 3;
  localparam logic REG_WRITE_ATTEMPTS = 1'b0;
  localparam logic REG_READ_ATTEMPTS  = 1'b1;
  localparam logic [7:0] WRITE_ATTEMPTS_RESET = 8'd3;
  localparam logic [7:0] READ_ATTEMPTS_RESET  = 8'd100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_data;
  } req_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_data;
    logic        last_of_run;
    logic        success;
    logic [15:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  slave;
    logic        is_write;
    logic [15:0] reg_addr;
    logic [15:0] data;
  } frame_t;

  typedef struct packed {
    logic        is_done;
    logic        ok;
    logic [15:0] value;
    frame_t      frame;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_byte(input frame_t f, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = f.slave;
      3'd1: b = f.is_write ? FN_WRITE : FN_READ;
      3'd2: b = f.reg_addr[15:8];
      3'd3: b = f.reg_addr[7:0];
      3'd4: b = f.data[15:8];
      default: b = f.data[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mrrm_front.sv
// Front end: accepts command words, tracks the transaction and checks the response bytes.
`default_nettype none
module mrrm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire mrrm_pkg::req_t req,
  output logic               req_stall,
  input  wire logic          full,
  input  wire logic [7:0]    write_attempts,
  input  wire logic [7:0]    read_attempts,
  output logic               push_valid,
  output mrrm_pkg::job_t     push_job
);

  logic             busy, busy_next;
  logic             op_is_write, op_is_write_next;
  mrrm_pkg::frame_t frame, frame_next;
  logic [3:0]       rx_count, rx_count_next;
  logic [15:0]      rx_crc, rx_crc_next;
  logic             rx_good, rx_good_next;
  logic [7:0]       attempts_left, attempts_left_next;
  logic [15:0]      value_hold, value_hold_next;

  logic       accept;
  logic       fail;
  logic       done_ok;
  logic       good;
  logic [7:0] expect_byte;
  logic [7:0] n_attempts;
  logic [3:0] count_inc;

  assign req_stall = full;
  assign accept    = req_valid && !full;
  assign count_inc = rx_count + 4'd1;

  always_comb begin
    busy_next          = busy;
    op_is_write_next   = op_is_write;
    frame_next         = frame;
    rx_count_next      = rx_count;
    rx_crc_next        = rx_crc;
    rx_good_next       = rx_good;
    attempts_left_next = attempts_left;
    value_hold_next    = value_hold;
    push_valid         = 1'b0;
    push_job           = '0;
    fail               = 1'b0;
    done_ok            = 1'b0;
    good               = rx_good;
    expect_byte        = '0;
    n_attempts         = '0;

    if (accept) begin
      case (req.cmd)
        mrrm_pkg::CMD_READ, mrrm_pkg::CMD_WRITE: begin
          if (!busy) begin
            op_is_write_next    = (req.cmd == mrrm_pkg::CMD_WRITE);
            frame_next.slave    = req.slave_addr;
            frame_next.is_write = op_is_write_next;
            frame_next.reg_addr = req.reg_addr;
            frame_next.data     = op_is_write_next ? req.write_value : mrrm_pkg::READ_COUNT_ONE;
            rx_count_next       = '0;
            rx_crc_next         = mrrm_pkg::CRC_INIT;
            rx_good_next        = 1'b1;
            value_hold_next     = '0;
            n_attempts          = op_is_write_next ? write_attempts : read_attempts;
            push_valid          = 1'b1;
            push_job.frame      = frame_next;
            if (n_attempts == 8'd0) begin
              busy_next        = 1'b0;
              push_job.is_done = 1'b1;
            end else begin
              busy_next          = 1'b1;
              attempts_left_next = n_attempts - 8'd1;
            end
          end
        end
        mrrm_pkg::CMD_TIMEOUT: begin
          fail = busy;
        end
        default: begin
          if (busy) begin
            if (op_is_write) begin
              if (rx_count < 4'd6) begin
                expect_byte = mrrm_pkg::frame_byte(frame, rx_count[2:0]);
                rx_crc_next = mrrm_pkg::crc_byte(rx_crc, req.rx_data);
              end else if (rx_count == 4'd6) begin
                expect_byte = rx_crc[7:0];
              end else begin
                expect_byte = rx_crc[15:8];
              end
              good = rx_good && (req.rx_data == expect_byte);
              rx_good_next  = good;
              rx_count_next = count_inc;
              if (count_inc >= 4'd8) begin
                done_ok = good;
                fail    = !good;
              end
            end else begin
              case (rx_count)
                4'd0: good = rx_good && (req.rx_data == frame.slave);
                4'd1: good = rx_good && (req.rx_data == mrrm_pkg::FN_READ);
                4'd2: good = rx_good && (req.rx_data == mrrm_pkg::BYTE_COUNT_ONE);
                4'd3: value_hold_next = {req.rx_data, 8'h00};
                4'd4: value_hold_next = {value_hold[15:8], req.rx_data};
                4'd5: good = rx_good && (req.rx_data == rx_crc[7:0]);
                default: good = rx_good && (req.rx_data == rx_crc[15:8]);
              endcase
              if (rx_count < 4'd5) begin
                rx_crc_next = mrrm_pkg::crc_byte(rx_crc, req.rx_data);
              end
              rx_good_next  = good;
              rx_count_next = count_inc;
              if (count_inc >= 4'd7) begin
                done_ok = good;
                fail    = !good;
              end
            end
          end
        end
      endcase

      if (done_ok) begin
        busy_next        = 1'b0;
        push_valid       = 1'b1;
        push_job.is_done = 1'b1;
        push_job.ok      = 1'b1;
        push_job.value   = op_is_write ? 16'h0000 : value_hold_next;
      end

      if (fail) begin
        push_valid = 1'b1;
        if (attempts_left == 8'd0) begin
          busy_next        = 1'b0;
          push_job.is_done = 1'b1;
        end else begin
          attempts_left_next = attempts_left - 8'd1;
          push_job.frame     = frame;
          rx_count_next      = '0;
          rx_crc_next        = mrrm_pkg::CRC_INIT;
          rx_good_next       = 1'b1;
          value_hold_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      op_is_write   <= 1'b0;
      rx_count      <= '0;
      rx_crc        <= mrrm_pkg::CRC_INIT;
      rx_good       <= 1'b1;
      attempts_left <= '0;
      value_hold    <= '0;
    end else begin
      busy          <= busy_next;
      op_is_write   <= op_is_write_next;
      rx_count      <= rx_count_next;
      rx_crc        <= rx_crc_next;
      rx_good       <= rx_good_next;
      attempts_left <= attempts_left_next;
      value_hold    <= value_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    frame <= frame_next;
  end

endmodule
`default_nettype wire

// File: rtl/mrrm_queue.sv
// Job queue between the front end and the back end.
`default_nettype none
module mrrm_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire mrrm_pkg::job_t push_job,
  output logic                full,
  output logic                head_valid,
  output mrrm_pkg::job_t      head_job,
  input  wire logic           pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mrrm_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push_valid, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/mrrm_back.sv
// Back end: turns queued jobs into transmit and completion words, appending the request CRC.
`default_nettype none
module mrrm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire mrrm_pkg::job_t head_job,
  output logic                pop,
  output logic                rsp_valid,
  output mrrm_pkg::rsp_t      rsp,
  input  wire logic           rsp_stall
);

  logic [2:0]     idx, idx_next;
  logic [15:0]    crc, crc_next;
  logic           slot_free;
  logic           emit;
  mrrm_pkg::rsp_t word;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign emit      = slot_free && head_valid;

  always_comb begin
    word     = '0;
    pop      = 1'b0;
    idx_next = idx;
    crc_next = crc;
    if (head_job.is_done) begin
      word.out_kind    = mrrm_pkg::KIND_DONE;
      word.last_of_run = 1'b1;
      word.success     = head_job.ok;
      word.read_value  = head_job.value;
      pop              = emit;
    end else begin
      word.out_kind = mrrm_pkg::KIND_TX;
      if (idx < 3'd6) begin
        word.tx_data = mrrm_pkg::frame_byte(head_job.frame, idx);
        crc_next     = mrrm_pkg::crc_byte(crc, word.tx_data);
      end else if (idx == 3'd6) begin
        word.tx_data = crc[7:0];
      end else begin
        word.tx_data = crc[15:8];
      end
      word.last_of_run = (idx == 3'd7);
      pop              = emit && word.last_of_run;
      idx_next         = idx + 3'd1;
    end
    if (pop) begin
      idx_next = '0;
      crc_next = mrrm_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      idx       <= '0;
      crc       <= mrrm_pkg::CRC_INIT;
    end else if (slot_free) begin
      rsp_valid <= head_valid;
      if (emit) begin
        idx <= idx_next;
        crc <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= word;
    end
  end

endmodule
`default_nettype wire

// File: rtl/modbus_rtu_register_master.sv
// Top level of the Modbus RTU single-register master with its APB register port.
`default_nettype none
// Each command word is accepted whenever the job queue has room, so words can arrive back
// to back. A start with attempts left, or a resend, queues one job that the back end plays
// out as eight transmit words, the last two carrying the CRC it computes as the bytes go
// by; a completion is a single word. Sustained throughput is therefore bounded by the
// result port at one word per cycle while not stalled, and the QUEUE_DEPTH-entry job queue
// lets the front end keep checking received bytes while a request is still being sent.
module modbus_rtu_register_master #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire mrrm_pkg::req_t                req,
  output logic                               req_stall,
  output logic                               rsp_valid,
  output mrrm_pkg::rsp_t                     rsp,
  input  wire logic                          rsp_stall,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mrrm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [7:0]     write_attempts;
  logic [7:0]     read_attempts;
  logic           full;
  logic           push_valid;
  mrrm_pkg::job_t push_job;
  logic           head_valid;
  mrrm_pkg::job_t head_job;
  logic           pop;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = {24'h000000,
                    (reg_sel == mrrm_pkg::REG_READ_ATTEMPTS) ? read_attempts : write_attempts};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_attempts <= mrrm_pkg::WRITE_ATTEMPTS_RESET;
      read_attempts  <= mrrm_pkg::READ_ATTEMPTS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        mrrm_pkg::REG_WRITE_ATTEMPTS: write_attempts <= pwdata[7:0];
        default:                      read_attempts  <= pwdata[7:0];
      endcase
    end
  end

  mrrm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req            (req),
    .req_stall      (req_stall),
    .full           (full),
    .write_attempts (write_attempts),
    .read_attempts  (read_attempts),
    .push_valid     (push_valid),
    .push_job       (push_job)
  );

  mrrm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  mrrm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .rsp_stall  (rsp_stall)
  );

endmodule
`default_nettype wire

// File: rtl/mrrm_checker.sv
// Port-level checker for the Modbus RTU register master, bound to the top level.
`default_nettype none
module mrrm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire mrrm_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_kind == mrrm_pkg::KIND_DONE |-> rsp.last_of_run)
    else $error("completion word without last_of_run");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_kind == mrrm_pkg::KIND_TX |-> !rsp.success && rsp.read_value == 16'h0000)
    else $error("transmit word carries completion status");

  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_kind == mrrm_pkg::KIND_DONE && !rsp.success |->
      rsp.read_value == 16'h0000)
    else $error("failed completion carries a value");

  a_tx_then_more: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && rsp.out_kind == mrrm_pkg::KIND_TX && !rsp.last_of_run |=>
      rsp_valid && rsp.out_kind == mrrm_pkg::KIND_TX)
    else $error("transmit run broken before its last byte");

endmodule

bind modbus_rtu_register_master mrrm_checker u_mrrm_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
